// ===== sv/lcd4ws_pkg.sv =====
// shared types, constants and helper functions for the lcd 4-bit write sequencer
// no dependencies; imported by every other file of the block except lcd4ws_if
package lcd4ws_pkg;

    localparam int SHORT_W = 10;
    localparam int LONG_W  = 16;
    localparam int WAIT_W  = 16;

    typedef logic [2:0] t_action;

    localparam t_action ACT_INSTR      = 3'd0;
    localparam t_action ACT_DATA       = 3'd1;
    localparam t_action ACT_CURSOR     = 3'd2;
    localparam t_action ACT_TEXT       = 3'd3;
    localparam t_action ACT_TEXT_START = 3'd4;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] INSTR_CLEAR  = 8'h01;
    localparam logic [7:0] INSTR_HOME   = 8'h02;
    localparam logic [7:0] CURSOR_CMD   = 8'h80;
    localparam logic [3:0] NIB_FUNC_SET = 4'h2;
    localparam logic [2:0] LINE_MAX     = 3'd4;

    // register indexes, selected by paddr[2]
    localparam logic REG_SHORT = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    localparam logic [SHORT_W-1:0] SHORT_RESET = 10'd40;
    localparam logic [LONG_W-1:0]  LONG_RESET  = 16'd2000;

    // one queued command: register select and the byte to send
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [SHORT_W-1:0] short_wait;
        logic [LONG_W-1:0]  long_wait;
    } t_waits;

    function automatic logic [6:0] line_base(input logic [2:0] line);
        logic [6:0] b;
        case (line)
            3'd0: b = 7'h00;
            3'd1: b = 7'h40;
            3'd2: b = 7'h14;
            3'd3: b = 7'h54;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cursor_addr(input logic [2:0] line, input logic [6:0] col);
        logic [6:0] s;
        s = line_base(line) + col;
        return CURSOR_CMD | {1'b0, s};
    endfunction

endpackage

// ===== sv/lcd4ws_if.sv =====
// valid/ready channel interfaces: request input and strobe output
// no dependencies
interface lcd4ws_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [2:0] row;
    logic [6:0] column;

    modport source(output valid, action, byte_value, row, column, input ready);
    modport sink(input valid, action, byte_value, row, column, output ready);
endinterface

interface lcd4ws_strobe_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        last;

    modport source(output valid, reg_select, nibble, wait_us, last, input ready);
    modport sink(input valid, reg_select, nibble, wait_us, last, output ready);
endinterface

// ===== sv/lcd_four_bit_write_sequencer.sv =====
// top level of the lcd 4-bit write sequencer: config registers, front end, queue, sequencer
// depends on lcd4ws_pkg, lcd4ws_if, lcd4ws_front, lcd4ws_queue, lcd4ws_back
//
// Each request becomes two nibble strobes (three for a function-set instruction, whose
// upper nibble is 2 and goes out twice), upper nibble first, the last one flagged. The
// front end classifies a request in the cycle it is accepted and places one command in
// a short queue; the strobe sequencer issues one strobe per cycle, while the strobe
// channel is not stalled, into an output register, and requests follow each other with
// no gap. Requests with an undefined action are taken and dropped. Hold times
// come from short_wait_us (address 0x0, reset 40) and long_wait_us (address 0x4, reset
// 2000); clear and home use the long one. Write them only while no transaction is in
// flight.
module lcd_four_bit_write_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lcd4ws_req_if.sink      i_req,
    lcd4ws_strobe_if.source o_strobe
);
    import lcd4ws_pkg::*;

    logic [SHORT_W-1:0] r_short_wait;
    logic [LONG_W-1:0]  r_long_wait;
    logic               cfg_wr;
    t_waits             waits;

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_cmd  f_cmd;
    t_cmd  q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_wait <= SHORT_RESET;
            r_long_wait  <= LONG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LONG) begin
                r_long_wait <= pwdata[LONG_W-1:0];
            end else begin
                r_short_wait <= pwdata[SHORT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SHORT) ? 32'(r_short_wait) : 32'(r_long_wait);

    assign waits.short_wait = r_short_wait;
    assign waits.long_wait  = r_long_wait;

    lcd4ws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    lcd4ws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    lcd4ws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_waits     (waits),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_strobe    (o_strobe)
    );

endmodule

// ===== sv/lcd4ws_front.sv =====
// front end: accepts requests, tracks the text line, turns each into a command byte
// depends on lcd4ws_pkg and lcd4ws_req_if
module lcd4ws_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcd4ws_req_if.sink        i_req,
    input  logic              i_full,
    output logic              o_push,
    output lcd4ws_pkg::t_cmd  o_cmd
);
    import lcd4ws_pkg::*;

    logic [2:0] r_line;
    logic [2:0] n_line;
    logic       accept;
    logic       kind_ok;
    t_cmd       cmd;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;

    always_comb begin
        n_line    = r_line;
        kind_ok   = 1'b1;
        cmd.rs    = 1'b0;
        cmd.value = i_req.byte_value;
        case (i_req.action)
            ACT_INSTR: begin
                cmd.rs = 1'b0;
            end
            ACT_DATA: begin
                cmd.rs = 1'b1;
            end
            ACT_CURSOR: begin
                cmd.value = cursor_addr(i_req.row, i_req.column);
            end
            ACT_TEXT: begin
                if (i_req.byte_value == CHAR_NEWLINE) begin
                    // line counter stops at four, which maps to the line zero base
                    n_line    = (r_line < LINE_MAX) ? r_line + 3'd1 : r_line;
                    cmd.value = cursor_addr(n_line, 7'd0);
                end else begin
                    cmd.rs = 1'b1;
                end
            end
            ACT_TEXT_START: begin
                n_line    = 3'd0;
                cmd.value = CURSOR_CMD;
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
    end

    assign o_push = accept && kind_ok;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= 3'd0;
        end else if (accept) begin
            r_line <= n_line;
        end
    end

endmodule

// ===== sv/lcd4ws_queue.sv =====
// short command queue between the front end and the strobe sequencer
// depends on lcd4ws_pkg
module lcd4ws_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcd4ws_pkg::t_cmd  i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output lcd4ws_pkg::t_cmd  o_cmd,
    input  logic              i_pop
);
    import lcd4ws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/lcd4ws_back.sv =====
// strobe sequencer: splits each queued command into nibble strobes with hold times
// depends on lcd4ws_pkg and lcd4ws_strobe_if
module lcd4ws_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcd4ws_pkg::t_waits i_waits,
    input  logic               i_cmd_valid,
    input  lcd4ws_pkg::t_cmd   i_cmd,
    output logic               o_pop,
    lcd4ws_strobe_if.source    o_strobe
);
    import lcd4ws_pkg::*;

    typedef enum logic [2:0] {
        ST_HI  = 3'b001,
        ST_DUP = 3'b010,
        ST_LO  = 3'b100
    } t_step;

    t_step              r_step;
    t_step              n_step;
    logic               r_valid;
    logic               r_rs;
    logic [3:0]         r_nibble;
    logic [WAIT_W-1:0]  r_wait;
    logic               r_last;

    logic [3:0]         nib;
    logic [WAIT_W-1:0]  wt;
    logic               lst;
    logic [WAIT_W-1:0]  short16;
    logic [WAIT_W-1:0]  cmd_wait;
    logic               dup;
    logic               load;

    assign short16 = WAIT_W'(i_waits.short_wait);
    // clear and home hold for the long wait on both nibbles
    assign cmd_wait = (!i_cmd.rs && (i_cmd.value == INSTR_CLEAR || i_cmd.value == INSTR_HOME))
                    ? i_waits.long_wait : short16;
    assign dup = !i_cmd.rs && (i_cmd.value[7:4] == NIB_FUNC_SET);

    always_comb begin
        nib    = i_cmd.value[7:4];
        wt     = cmd_wait;
        lst    = 1'b0;
        n_step = ST_HI;
        case (r_step)
            ST_HI: begin
                n_step = dup ? ST_DUP : ST_LO;
            end
            ST_DUP: begin
                wt     = short16;
                n_step = ST_LO;
            end
            ST_LO: begin
                nib    = i_cmd.value[3:0];
                lst    = 1'b1;
                n_step = ST_HI;
            end
            default: begin
                n_step = ST_HI;
            end
        endcase
    end

    assign load  = i_cmd_valid && (!r_valid || o_strobe.ready);
    assign o_pop = load && (r_step == ST_LO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= ST_HI;
        end else if (load) begin
            r_valid <= 1'b1;
            r_step  <= n_step;
        end else if (o_strobe.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs     <= i_cmd.rs;
            r_nibble <= nib;
            r_wait   <= wt;
            r_last   <= lst;
        end
    end

    assign o_strobe.valid      = r_valid;
    assign o_strobe.reg_select = r_rs;
    assign o_strobe.nibble     = r_nibble;
    assign o_strobe.wait_us    = r_wait;
    assign o_strobe.last       = r_last;

endmodule

// ===== verif/tb_lcd_four_bit_write_sequencer.sv =====
// self-checking testbench for the lcd 4-bit write sequencer: directed table, then random requests
// depends on lcd4ws_pkg, lcd4ws_if and the lcd_four_bit_write_sequencer top level
// strobes are predicted per accepted request and compared in order at the strobe channel
`timescale 1ns / 1ps

module tb_lcd_four_bit_write_sequencer;
    import lcd4ws_pkg::*;

    localparam t_action ACT_NONE_LO  = 3'd5;
    localparam t_action ACT_NONE_MID = 3'd6;
    localparam t_action ACT_NONE_HI  = 3'd7;
    localparam logic [15:0] SHORT0 = 16'(SHORT_RESET);
    localparam logic [15:0] LONG0  = LONG_RESET;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic [15:0] wait_us;
        logic        last;
    } t_strobe;

    // one request plus, for table rows, the strobes typed in by hand
    typedef struct packed {
        t_action    action;
        logic [7:0] byte_value;
        logic [2:0] row;
        logic [6:0] column;
        logic       typed;
        logic [1:0] n_typed;
        t_strobe    s0;
        t_strobe    s1;
        t_strobe    s2;
    } t_req_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd4ws_req_if    req_bus();
    lcd4ws_strobe_if strobe_bus();

    lcd_four_bit_write_sequencer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_req    (req_bus),
        .o_strobe (strobe_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [SHORT_W-1:0] short_w;
    logic [LONG_W-1:0]  long_w;
    logic [2:0]         line_no;
    t_strobe            pred_buf [3];
    int                 pred_n;

    t_strobe     pending_strobes [$];
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned err_count = 0;

    function automatic t_strobe stb(logic rs, logic [3:0] nib, logic [15:0] w, logic last);
        t_strobe s;
        s.rs      = rs;
        s.nib     = nib;
        s.wait_us = w;
        s.last    = last;
        return s;
    endfunction

    function automatic t_req_row typed_row(t_action a, logic [7:0] b, logic [2:0] rw,
                                           logic [6:0] col, logic [1:0] n,
                                           t_strobe s0, t_strobe s1, t_strobe s2);
        t_req_row r;
        r.action     = a;
        r.byte_value = b;
        r.row        = rw;
        r.column     = col;
        r.typed      = 1'b1;
        r.n_typed    = n;
        r.s0         = s0;
        r.s1         = s1;
        r.s2         = s2;
        return r;
    endfunction

    function automatic t_req_row plain_row(t_action a, logic [7:0] b, logic [2:0] rw,
                                           logic [6:0] col);
        t_req_row r;
        r = typed_row(a, b, rw, col, 2'd0, '0, '0, '0);
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] cursor_byte(logic [2:0] line, logic [6:0] col);
        logic [6:0] base;
        logic [6:0] sum;
        case (line)
            3'd0: base = 7'h00;
            3'd1: base = 7'h40;
            3'd2: base = 7'h14;
            3'd3: base = 7'h54;
            default: base = 7'h00;
        endcase
        sum = base + col;
        return CURSOR_CMD | {1'b0, sum};
    endfunction

    task automatic add_strobe(input logic rs, input logic [3:0] nib, input logic [15:0] w,
                              input logic last);
        pred_buf[pred_n] = stb(rs, nib, w, last);
        pred_n++;
    endtask

    task automatic add_instr(input logic [7:0] v);
        logic [15:0] w;
        w = (v == INSTR_CLEAR || v == INSTR_HOME) ? long_w : 16'(short_w);
        add_strobe(1'b0, v[7:4], w, 1'b0);
        // function set repeats its upper nibble, always with the short wait
        if (v[7:4] == NIB_FUNC_SET)
            add_strobe(1'b0, v[7:4], 16'(short_w), 1'b0);
        add_strobe(1'b0, v[3:0], w, 1'b1);
    endtask

    task automatic add_data(input logic [7:0] v);
        add_strobe(1'b1, v[7:4], 16'(short_w), 1'b0);
        add_strobe(1'b1, v[3:0], 16'(short_w), 1'b1);
    endtask

    task automatic predict_strobes(input t_req_row r);
        pred_n = 0;
        case (r.action)
            ACT_INSTR:  add_instr(r.byte_value);
            ACT_DATA:   add_data(r.byte_value);
            ACT_CURSOR: add_instr(cursor_byte(r.row, r.column));
            ACT_TEXT: begin
                if (r.byte_value == CHAR_NEWLINE) begin
                    // line counter saturates, the top value maps to line zero base
                    if (line_no < LINE_MAX)
                        line_no = line_no + 3'd1;
                    add_instr(cursor_byte(line_no, 7'd0));
                end else begin
                    add_data(r.byte_value);
                end
            end
            ACT_TEXT_START: begin
                line_no = 3'd0;
                add_instr(cursor_byte(3'd0, 7'd0));
            end
            default: ;
        endcase
    endtask

    task automatic issue_request(input t_req_row r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.action     <= r.action;
        req_bus.byte_value <= r.byte_value;
        req_bus.row        <= r.row;
        req_bus.column     <= r.column;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        predict_strobes(r);
        if (r.typed) begin
            if (r.n_typed > 2'd0) pending_strobes.push_back(r.s0);
            if (r.n_typed > 2'd1) pending_strobes.push_back(r.s1);
            if (r.n_typed > 2'd2) pending_strobes.push_back(r.s2);
        end else begin
            for (int k = 0; k < pred_n; k++)
                pending_strobes.push_back(pred_buf[k]);
        end
    endtask

    // lower valid, wait for every outstanding strobe, then let the pipeline settle
    task automatic drain_strobes();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_strobes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_SHORT)
            short_w = data[SHORT_W-1:0];
        else
            long_w = data[LONG_W-1:0];
    endtask

    function automatic t_req_row random_request();
        int unsigned k;
        t_action     a;
        logic [7:0]  b;
        k = $urandom_range(99);
        b = 8'($urandom_range(255));
        if (k < 24) begin
            a = ACT_INSTR;
            case ($urandom_range(9))
                0: b = INSTR_CLEAR;
                1: b = INSTR_HOME;
                2, 3: b = {NIB_FUNC_SET, 4'($urandom_range(15))};
                default: ;
            endcase
        end else if (k < 44) begin
            a = ACT_DATA;
        end else if (k < 62) begin
            a = ACT_CURSOR;
        end else if (k < 88) begin
            a = ACT_TEXT;
            if ($urandom_range(99) < 30)
                b = CHAR_NEWLINE;
        end else if (k < 94) begin
            a = ACT_TEXT_START;
        end else begin
            a = t_action'($urandom_range(ACT_NONE_HI, ACT_NONE_LO));
        end
        return plain_row(a, b, 3'($urandom_range(7)), 7'($urandom_range(127)));
    endfunction

    always @(posedge i_clk) begin : strobe_check
        t_strobe want;
        if (i_rst_n && strobe_bus.valid && strobe_bus.ready) begin
            if (pending_strobes.size() == 0) begin
                $error("unexpected strobe transaction: rs %0d nibble %0h wait %0d last %0d",
                       strobe_bus.reg_select, strobe_bus.nibble, strobe_bus.wait_us,
                       strobe_bus.last);
                err_count++;
            end else begin
                want = pending_strobes.pop_front();
                if (strobe_bus.reg_select !== want.rs) begin
                    $error("reg_select: expected %0d, got %0d", want.rs, strobe_bus.reg_select);
                    err_count++;
                end
                if (strobe_bus.nibble !== want.nib) begin
                    $error("nibble: expected %0h, got %0h", want.nib, strobe_bus.nibble);
                    err_count++;
                end
                if (strobe_bus.wait_us !== want.wait_us) begin
                    $error("wait_us: expected %0d, got %0d", want.wait_us, strobe_bus.wait_us);
                    err_count++;
                end
                if (strobe_bus.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, strobe_bus.last);
                    err_count++;
                end
            end
        end
        strobe_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("lcd_four_bit_write_sequencer regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_req_row rows [$];
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_bus.valid      = 1'b0;
        req_bus.action     = ACT_INSTR;
        req_bus.byte_value = '0;
        req_bus.row        = '0;
        req_bus.column     = '0;
        short_w            = SHORT_RESET;
        long_w             = LONG_RESET;
        line_no            = 3'd0;
        src_idle_pct       = 17;
        sink_idle_pct      = 81;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, run with the reset hold times
        rows.push_back(typed_row(ACT_INSTR, INSTR_CLEAR, 3'd0, 7'd0, 2'd2,
            stb(1'b0, 4'h0, LONG0, 1'b0), stb(1'b0, 4'h1, LONG0, 1'b1), '0));
        rows.push_back(typed_row(ACT_INSTR, INSTR_HOME, 3'd7, 7'd127, 2'd2,
            stb(1'b0, 4'h0, LONG0, 1'b0), stb(1'b0, 4'h2, LONG0, 1'b1), '0));
        rows.push_back(typed_row(ACT_INSTR, 8'h00, 3'd0, 7'd0, 2'd2,
            stb(1'b0, 4'h0, SHORT0, 1'b0), stb(1'b0, 4'h0, SHORT0, 1'b1), '0));
        rows.push_back(typed_row(ACT_INSTR, 8'hFF, 3'd7, 7'd127, 2'd2,
            stb(1'b0, 4'hF, SHORT0, 1'b0), stb(1'b0, 4'hF, SHORT0, 1'b1), '0));
        rows.push_back(typed_row(ACT_INSTR, 8'h28, 3'd0, 7'd0, 2'd3,
            stb(1'b0, 4'h2, SHORT0, 1'b0), stb(1'b0, 4'h2, SHORT0, 1'b0),
            stb(1'b0, 4'h8, SHORT0, 1'b1)));
        rows.push_back(plain_row(ACT_INSTR, 8'h20, 3'd0, 7'd0));
        rows.push_back(typed_row(ACT_DATA, 8'h00, 3'd0, 7'd0, 2'd2,
            stb(1'b1, 4'h0, SHORT0, 1'b0), stb(1'b1, 4'h0, SHORT0, 1'b1), '0));
        rows.push_back(typed_row(ACT_DATA, 8'hFF, 3'd7, 7'd127, 2'd2,
            stb(1'b1, 4'hF, SHORT0, 1'b0), stb(1'b1, 4'hF, SHORT0, 1'b1), '0));
        rows.push_back(plain_row(ACT_DATA, 8'hA5, 3'd2, 7'd42));
        rows.push_back(typed_row(ACT_CURSOR, 8'h00, 3'd0, 7'd0, 2'd2,
            stb(1'b0, 4'h8, SHORT0, 1'b0), stb(1'b0, 4'h0, SHORT0, 1'b1), '0));
        // line base plus column wraps within 7 bits
        rows.push_back(plain_row(ACT_CURSOR, 8'h00, 3'd3, 7'd127));
        rows.push_back(plain_row(ACT_CURSOR, 8'h55, 3'd1, 7'd5));
        // rows above three fall back to line zero base
        rows.push_back(typed_row(ACT_CURSOR, 8'hFF, 3'd7, 7'd127, 2'd2,
            stb(1'b0, 4'hF, SHORT0, 1'b0), stb(1'b0, 4'hF, SHORT0, 1'b1), '0));
        rows.push_back(plain_row(ACT_CURSOR, 8'h00, 3'd4, 7'd64));
        rows.push_back(plain_row(ACT_TEXT_START, 8'h00, 3'd0, 7'd0));
        rows.push_back(plain_row(ACT_TEXT, 8'h41, 3'd0, 7'd0));
        // newlines walk the line counter up to its saturation point and beyond
        repeat (5) rows.push_back(plain_row(ACT_TEXT, CHAR_NEWLINE, 3'd5, 7'd99));
        rows.push_back(plain_row(ACT_TEXT, 8'hFF, 3'd7, 7'd127));
        rows.push_back(typed_row(ACT_NONE_HI, 8'hFF, 3'd7, 7'd127, 2'd0, '0, '0, '0));
        rows.push_back(plain_row(ACT_NONE_LO, 8'h02, 3'd0, 7'd0));
        rows.push_back(plain_row(ACT_NONE_MID, 8'h01, 3'd3, 7'd1));

        foreach (rows[i])
            issue_request(rows[i]);
        drain_strobes();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    apb_write({REG_SHORT, 2'b00}, 32'd1);
                    apb_write({REG_LONG, 2'b00}, 32'd65535);
                end
                1: begin
                    src_idle_pct  = 81;
                    sink_idle_pct = 17;
                    apb_write({REG_SHORT, 2'b00}, 32'd1023);
                    apb_write({REG_LONG, 2'b00}, 32'd1);
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    // junk above the register width is dropped
                    apb_write({REG_SHORT, 2'b00}, 32'hFFFF_FC00 | $urandom_range(1023, 1));
                    apb_write({REG_LONG, 2'b00}, 32'hABCD_0000 | $urandom_range(65535, 1));
                end
            endcase
            for (int i = 0; i < 90; i++) begin
                issue_request(random_request());
                if (p == 0 && i == 45)
                    drain_strobes();
            end
            drain_strobes();
        end

        if (err_count == 0)
            $display("lcd_four_bit_write_sequencer regression: pass");
        else
            $display("lcd_four_bit_write_sequencer regression: fail");
        $finish;
    end

endmodule
